/* hdl/rti_pkg.sv */
package rti_pkg;

  // coordinate and intermediate widths
  localparam int CW    = 32;           // Q16.16 coordinate
  localparam int EW    = CW + 1;       // edge and offset vectors
  localparam int XW    = 2 * EW;       // one cross product term
  localparam int PW    = XW + 1;       // cross product component
  localparam int LOW   = 34;           // low slice of a split multiplicand
  localparam int MW    = EW + PW;      // one dot product term
  localparam int SW    = MW + 3;       // dot product sum
  localparam int NW    = SW + 16;      // numerator scaled by 2^16
  localparam int QB    = 31;           // quotient bits below saturation
  localparam int RW    = SW + QB;      // divider remainder
  localparam int NDOT  = 4;
  localparam int NPROD = 3 * NDOT;
  localparam int PRE   = 8;            // stages ahead of the divider
  localparam int POST  = 3;            // stages after the divider
  localparam int LAT   = PRE + QB + POST;

  localparam logic [16:0] Q_ONE = 17'h10000;

  // register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_LIMIT    = 3'd6
  } cfg_idx_t;

  localparam logic [CW-1:0] DIR_Z_RST = 32'h0001_0000;
  localparam logic [15:0]   LIMIT_RST = 16'd1;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
  } tri_t;

  typedef struct packed {
    logic                 hit;
    logic [CW-2:0]        distance;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
  } res_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [SW-1:0] den;
    logic [QB-1:0] quo;
    logic          neg;
    logic          sat;
  } div_t;

endpackage

/* hdl/ray_triangle_intersect.sv */
// throughput: one triangle per cycle while the result side does not stall;
// 8 stages of edges, cross and dot products, 31 restoring-divider stages
// (one quotient bit each), 3 output stages
// a stall on the result side freezes the whole pipeline, nothing is dropped
// reset: ray registers go to origin 0, direction (0,0,1.0), limit 1; pipeline empties
module ray_triangle_intersect import rti_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tri_t          in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output res_t          out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [CW-1:0] cfg_wdata
);

  logic signed [CW-1:0] org_r [3];
  logic signed [CW-1:0] dir_r [3];
  logic [15:0]          lim_r;

  logic [LAT-1:0] vld_r;
  logic           adv;

  // stage registers
  logic signed [EW-1:0] e1_r [3], e2_r [3], s_r [3];
  logic signed [XW-1:0] ph_r [6], pq_r [6];
  logic signed [EW-1:0] e1_2_r [3], e2_2_r [3], s_2_r [3];
  logic signed [PW-1:0] h_r [3], q_r [3];
  logic signed [EW-1:0] e1_3_r [3], e2_3_r [3], s_3_r [3];
  logic signed [EW+LOW:0]       plo_r [NPROD];
  logic signed [EW+PW-LOW-1:0]  phi_r [NPROD];
  logic signed [MW-1:0] prod_r [NPROD];
  logic signed [SW-1:0] dot_r [NDOT];
  logic [SW-1:0]        den_r;
  logic [NW-1:0]        num_r [3];
  logic                 neg_r [3];
  logic                 dok_r;
  div_t                 dv_r  [QB+1][3];
  div_t                 dv_nxt [QB][3];
  logic                 ok_r  [QB+1];
  logic signed [CW-1:0] uvt_r [3];
  logic                 ok_p1_r;
  logic                 hit_r;
  logic signed [CW-1:0] t_p2_r;
  logic signed [2*CW-1:0] p_r [3];
  res_t                 out_r;

  // combinational helpers
  logic signed [EW-1:0] e1_nxt [3], e2_nxt [3], s_nxt [3];
  logic signed [CW-1:0] va [3], vb [3], vc [3];
  logic signed [EW-1:0] dd [3];
  logic signed [EW-1:0] pa [NPROD];
  logic signed [PW-1:0] pb [NPROD];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
      end
      dir_r[2] <= DIR_Z_RST;
      lim_r    <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_ORIGIN_X: org_r[0] <= cfg_wdata;
        REG_ORIGIN_Y: org_r[1] <= cfg_wdata;
        REG_ORIGIN_Z: org_r[2] <= cfg_wdata;
        REG_DIR_X:    dir_r[0] <= cfg_wdata;
        REG_DIR_Y:    dir_r[1] <= cfg_wdata;
        REG_DIR_Z:    dir_r[2] <= cfg_wdata;
        REG_LIMIT:    lim_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves unless the output beat is stuck
  assign adv      = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // edges and origin offset
  always_comb begin
    va[0] = in_data.a_x; va[1] = in_data.a_y; va[2] = in_data.a_z;
    vb[0] = in_data.b_x; vb[1] = in_data.b_y; vb[2] = in_data.b_z;
    vc[0] = in_data.c_x; vc[1] = in_data.c_y; vc[2] = in_data.c_z;
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = {vb[i][CW-1], vb[i]} - {va[i][CW-1], va[i]};
      e2_nxt[i] = {vc[i][CW-1], vc[i]} - {va[i][CW-1], va[i]};
      s_nxt[i]  = {org_r[i][CW-1], org_r[i]} - {va[i][CW-1], va[i]};
      dd[i]     = {dir_r[i][CW-1], dir_r[i]};
    end
  end

  // dot product operands: det, u, v and t numerators
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i]     = e1_3_r[i]; pb[i]     = h_r[i];
      pa[3+i]   = s_3_r[i];  pb[3+i]   = h_r[i];
      pa[6+i]   = dd[i];     pb[6+i]   = q_r[i];
      pa[9+i]   = e2_3_r[i]; pb[9+i]   = q_r[i];
    end
  end

  // front stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= e1_nxt[i];
        e2_r[i] <= e2_nxt[i];
        s_r[i]  <= s_nxt[i];
        e1_2_r[i] <= e1_r[i];
        e2_2_r[i] <= e2_r[i];
        s_2_r[i]  <= s_r[i];
        e1_3_r[i] <= e1_2_r[i];
        e2_3_r[i] <= e2_2_r[i];
        s_3_r[i]  <= s_2_r[i];
      end
      // h = dir x e2, q = s x e1 terms
      ph_r[0] <= dd[1] * e2_r[2];  ph_r[1] <= dd[2] * e2_r[1];
      ph_r[2] <= dd[2] * e2_r[0];  ph_r[3] <= dd[0] * e2_r[2];
      ph_r[4] <= dd[0] * e2_r[1];  ph_r[5] <= dd[1] * e2_r[0];
      pq_r[0] <= s_r[1] * e1_r[2]; pq_r[1] <= s_r[2] * e1_r[1];
      pq_r[2] <= s_r[2] * e1_r[0]; pq_r[3] <= s_r[0] * e1_r[2];
      pq_r[4] <= s_r[0] * e1_r[1]; pq_r[5] <= s_r[1] * e1_r[0];
      for (int i = 0; i < 3; i++) begin
        h_r[i] <= ph_r[2*i] - ph_r[2*i+1];
        q_r[i] <= pq_r[2*i] - pq_r[2*i+1];
      end
      // split multiply: low slice unsigned, high slice signed
      for (int k = 0; k < NPROD; k++) begin
        plo_r[k] <= pa[k] * $signed({1'b0, pb[k][LOW-1:0]});
        phi_r[k] <= pa[k] * $signed(pb[k][PW-1:LOW]);
      end
      for (int k = 0; k < NPROD; k++) begin
        prod_r[k] <= $signed({phi_r[k], {LOW{1'b0}}}) + plo_r[k];
      end
      for (int j = 0; j < NDOT; j++) begin
        dot_r[j] <= prod_r[3*j] + prod_r[3*j+1] + prod_r[3*j+2];
      end
    end
  end

  // magnitudes, signs and determinant test
  logic [SW-1:0] dabs;
  logic [SW-1:0] nabs [3];
  always_comb begin
    dabs = dot_r[0][SW-1] ? SW'(-dot_r[0]) : SW'(dot_r[0]);
    for (int l = 0; l < 3; l++) begin
      nabs[l] = dot_r[l+1][SW-1] ? SW'(-dot_r[l+1]) : SW'(dot_r[l+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r <= dabs;
      dok_r <= !(dabs < SW'({lim_r, 32'd0})) && (dabs != '0);
      for (int l = 0; l < 3; l++) begin
        num_r[l] <= {nabs[l], 16'd0};
        neg_r[l] <= dot_r[l+1][SW-1] ^ dot_r[0][SW-1];
      end
    end
  end

  // restoring divider, one quotient bit per stage
  always_comb begin
    for (int g = 0; g < QB; g++) begin
      for (int l = 0; l < 3; l++) begin
        dv_nxt[g][l] = dv_r[g][l];
        if (dv_r[g][l].rem >= (RW'(dv_r[g][l].den) << (QB - 1 - g))) begin
          dv_nxt[g][l].rem = dv_r[g][l].rem - (RW'(dv_r[g][l].den) << (QB - 1 - g));
          dv_nxt[g][l].quo[QB-1-g] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // divider entry with saturation check
      ok_r[0] <= dok_r;
      for (int l = 0; l < 3; l++) begin
        dv_r[0][l].rem <= RW'(num_r[l]);
        dv_r[0][l].den <= den_r;
        dv_r[0][l].quo <= '0;
        dv_r[0][l].neg <= neg_r[l];
        dv_r[0][l].sat <= RW'(num_r[l]) >= (RW'(den_r) << QB);
      end
      for (int g = 0; g < QB; g++) begin
        ok_r[g+1] <= ok_r[g];
        for (int l = 0; l < 3; l++) begin
          dv_r[g+1][l] <= dv_nxt[g][l];
        end
      end
    end
  end

  // signed, saturated quotients
  always_ff @(posedge clk) begin
    if (adv) begin
      ok_p1_r <= ok_r[QB];
      for (int l = 0; l < 3; l++) begin
        if (dv_r[QB][l].sat) begin
          uvt_r[l] <= dv_r[QB][l].neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (dv_r[QB][l].neg) begin
          uvt_r[l] <= 32'(-{1'b0, dv_r[QB][l].quo});
        end else begin
          uvt_r[l] <= {1'b0, dv_r[QB][l].quo};
        end
      end
    end
  end

  // barycentric and distance tests, direction times t
  logic signed [CW:0] uv_sum;
  logic               hit_nxt;
  always_comb begin
    uv_sum  = {uvt_r[0][CW-1], uvt_r[0]} + {uvt_r[1][CW-1], uvt_r[1]};
    hit_nxt = ok_p1_r
              && !uvt_r[0][CW-1]
              && ($signed({1'b0, uvt_r[0]}) <= $signed({16'd0, Q_ONE}))
              && !uvt_r[1][CW-1]
              && (uv_sum <= $signed({16'd0, Q_ONE}))
              && (uvt_r[2] > $signed({16'd0, lim_r}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r  <= hit_nxt;
      t_p2_r <= uvt_r[2];
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= dir_r[i] * uvt_r[2];
      end
    end
  end

  // hit point: origin plus truncated offset, saturated
  logic [2*CW-1:0]      mag [3];
  logic [CW+17:0]       off [3];
  logic [CW+17:0]       sum [3];
  logic signed [CW-1:0] hp  [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = p_r[i][2*CW-1] ? 64'(-p_r[i]) : 64'(p_r[i]);
      off[i] = p_r[i][2*CW-1] ? 50'(-{2'b0, mag[i][2*CW-1:16]})
                              : {2'b0, mag[i][2*CW-1:16]};
      sum[i] = {{18{org_r[i][CW-1]}}, org_r[i]} + off[i];
      if (sum[i][CW+17:CW-1] == '0 || sum[i][CW+17:CW-1] == '1) begin
        hp[i] = sum[i][CW-1:0];
      end else if (sum[i][CW+17]) begin
        hp[i] = 32'sh8000_0000;
      end else begin
        hp[i] = 32'sh7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (hit_r) begin
        out_r.hit      <= 1'b1;
        out_r.distance <= t_p2_r[CW-2:0];
        out_r.hit_x    <= hp[0];
        out_r.hit_y    <= hp[1];
        out_r.hit_z    <= hp[2];
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // an accepted beat enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted beat did not enter the pipeline");

  // a miss reports zeros everywhere
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |->
      out_data.distance == '0 && out_data.hit_x == '0 &&
      out_data.hit_y == '0 && out_data.hit_z == '0)
    else $error("miss carries nonzero payload");

  // a hit is always beyond the limit
  a_hit_far: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.distance > 31'(lim_r))
    else $error("hit distance not beyond limit");
`endif

endmodule
